>>> hw/rtl/scaled_log10_power_to_db_core_defines.svh
// Assertion macros shared by the block's RTL files.
`ifndef SCALED_LOG10_POWER_TO_DB_CORE_DEFINES_SVH
`define SCALED_LOG10_POWER_TO_DB_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define SLDB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("sldb check failed");
// Check on every clock edge, reset included.
`define SLDB_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error("sldb reset check failed");
`else
`define SLDB_ASSERT(lbl, prop)
`define SLDB_ASSERT_RST(lbl, prop)
`endif
`endif

>>> hw/rtl/sldb_pkg.sv
package sldb_pkg;

	// Float layout
	localparam int MANT_BITS = 23;
	localparam int EXP_BITS  = 8;
	localparam int EXP_BIAS  = 127;

	// Table and interpolation sizing
	localparam int TABLE_INDEX_BITS = 6;
	localparam int INTERP_FRAC_BITS = 16;
	localparam int REM_BITS         = MANT_BITS - TABLE_INDEX_BITS;
	localparam int ROM_ENTRIES      = (1 << TABLE_INDEX_BITS) + 1;
	localparam int ROM_AW           = TABLE_INDEX_BITS + 1;
	localparam int ENTRY_W          = INTERP_FRAC_BITS + 1;
	localparam int MUL_W            = ENTRY_W + REM_BITS;

	// log2 value: 9-bit signed exponent over the fraction bits
	localparam int L2_W = INTERP_FRAC_BITS + EXP_BITS + 1;

	// Scaling and output
	localparam int CFG_W     = 24;
	localparam int LEVEL_W   = 24;
	localparam int OUT_FRAC  = 8;
	localparam int PROD_W    = L2_W + CFG_W;
	localparam int DROP_BITS = INTERP_FRAC_BITS + OUT_FRAC;
	localparam int SHIFT_W   = PROD_W - DROP_BITS;
	localparam int SUM_W     = SHIFT_W + 1;

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (DROP_BITS - 1);

	// log2 of the smallest normal value
	localparam logic signed [L2_W-1:0] CLAMP_L2 =
		L2_W'(-(126 * (1 << INTERP_FRAC_BITS)));

	// Configuration registers
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DB = 2'd1;
	localparam logic signed [CFG_W-1:0] LOG_SCALE_RST = 24'sd197283;
	localparam logic signed [CFG_W-1:0] OFFSET_DB_RST = 24'sd0;

	typedef logic [ENTRY_W-1:0] rom_entry_t;
	typedef rom_entry_t rom_t [ROM_ENTRIES];

	// Item leaving the log2 stages
	typedef struct packed {
		logic                   valid;
		logic                   clamped;
		logic signed [L2_W-1:0] l2;
	} l2_item_t;

	// Build log2(1 + i/2^TABLE_INDEX_BITS) by repeated squaring of a Q30 value,
	// one spare bit, rounded half up; last point is exactly 1.0.
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] y;
		logic [63:0] acc;
		for (int i = 0; i < ROM_ENTRIES - 1; i++) begin
			y   = (64'd1 << 30) + (64'(i) << (30 - TABLE_INDEX_BITS));
			acc = 64'd0;
			for (int b = 0; b < INTERP_FRAC_BITS + 1; b++) begin
				y   = (y * y) >> 30;
				acc = acc << 1;
				if (y >= (64'd1 << 31)) begin
					y      = y >> 1;
					acc[0] = 1'b1;
				end
			end
			rom[i] = ENTRY_W'((acc + 64'd1) >> 1);
		end
		rom[ROM_ENTRIES-1] = ENTRY_W'(1) << INTERP_FRAC_BITS;
		return rom;
	endfunction

	localparam rom_t LOG_ROM = build_rom();

endpackage

>>> hw/rtl/sldb_log2_unit.sv
`include "scaled_log10_power_to_db_core_defines.svh"

module sldb_log2_unit import sldb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample_bits,
	output l2_item_t    l2_item,
	input  logic        l2_ready
);

	logic en1, en2, en3;

	logic                    valid_s1, clamped_s1;
	logic [EXP_BITS-1:0]     exp_s1;
	logic [REM_BITS-1:0]     rem_s1;
	rom_entry_t              t0_s1, t1_s1;

	logic                    valid_s2, clamped_s2;
	logic [EXP_BITS-1:0]     exp_s2;
	rom_entry_t              t0_s2;
	logic [MUL_W-1:0]        mul_s2;

	logic                    valid_s3, clamped_s3;
	logic signed [L2_W-1:0]  l2_s3;

	logic                    clamp_d;
	logic [EXP_BITS-1:0]     exp_raw, exp_d;
	logic [MANT_BITS-1:0]    mant_raw, mant_d;
	logic [TABLE_INDEX_BITS-1:0] idx_d;
	logic [ROM_AW-1:0]       addr0, addr1;
	rom_entry_t              diff;
	rom_entry_t              frac;
	logic signed [EXP_BITS:0] exp_unb;

	// Advance a stage when it is empty or the next one moves
	assign en3      = !valid_s3 || l2_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// Decode the float and clamp sign, zero, denormal and NaN
	assign exp_raw  = sample_bits[MANT_BITS +: EXP_BITS];
	assign mant_raw = sample_bits[MANT_BITS-1:0];
	assign clamp_d  = sample_bits[31] || (exp_raw == '0) ||
		((exp_raw == '1) && (mant_raw != '0));
	assign exp_d    = clamp_d ? EXP_BITS'(1) : exp_raw;
	assign mant_d   = clamp_d ? '0 : mant_raw;
	assign idx_d    = mant_d[MANT_BITS-1 -: TABLE_INDEX_BITS];
	assign addr0    = {1'b0, idx_d};
	assign addr1    = addr0 + ROM_AW'(1);

	// Stage 1: table lookup of both neighbor points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			clamped_s1 <= clamp_d;
			exp_s1     <= exp_d;
			rem_s1     <= mant_d[REM_BITS-1:0];
			t0_s1      <= LOG_ROM[addr0];
			t1_s1      <= LOG_ROM[addr1];
		end
	end

	// Stage 2: slope times remainder
	assign diff = t1_s1 - t0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			clamped_s2 <= clamped_s1;
			exp_s2     <= exp_s1;
			t0_s2      <= t0_s1;
			mul_s2     <= MUL_W'(diff) * MUL_W'(rem_s1);
		end
	end

	// Stage 3: add interpolated fraction to the unbiased exponent
	assign frac    = t0_s2 + ENTRY_W'(mul_s2 >> REM_BITS);
	assign exp_unb = $signed({1'b0, exp_s2}) - (EXP_BITS+1)'(EXP_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			clamped_s3 <= clamped_s2;
			l2_s3      <= $signed({exp_unb, {INTERP_FRAC_BITS{1'b0}}}) +
				$signed({{(L2_W-ENTRY_W){1'b0}}, frac});
		end
	end

	assign l2_item.valid   = valid_s3;
	assign l2_item.clamped = clamped_s3;
	assign l2_item.l2      = l2_s3;

	`SLDB_ASSERT(a_rom_monotone, valid_s1 |-> (t1_s1 >= t0_s1))
	`SLDB_ASSERT(a_clamp_l2, (valid_s3 && clamped_s3) |-> (l2_s3 == CLAMP_L2))
	`SLDB_ASSERT(a_s2_hold, (valid_s2 && !en3) |=> (valid_s2 && $stable(mul_s2)))
	`SLDB_ASSERT_RST(a_rst_empty, !arst_n |=> (!valid_s1 && !valid_s2 && !valid_s3))

endmodule

>>> hw/rtl/scaled_log10_power_to_db_core.sv
// Power to decibel converter: level = log_scale * log2(x) + offset_db.
// Input channel: sample_bits is a single-precision bit pattern, taken when
// in_valid and in_ready are both high. Output channel: level (signed, 8
// fraction bits, saturated) and clamped, taken when out_valid and out_ready
// are both high. Zero, negative, denormal and NaN samples are replaced by
// the smallest normal value and flagged with clamped.
// An accepted item passes through the register stages table lookup,
// interpolation multiply, log2 assembly, scale multiply and
// round/offset/saturate before out_valid; throughput is one item per cycle
// while out_ready is high. When out_ready is low the pipeline holds; empty
// stages still fill, so in_ready stays high until every stage holds an item.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 log_scale,
// 1 offset_db) at the clock edge; other indexes are ignored. Write only
// while the pipeline is empty.
// Reset empties all stages and loads log_scale = 197283, offset_db = 0.
`include "scaled_log10_power_to_db_core_defines.svh"

module scaled_log10_power_to_db_core import sldb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          sample_bits,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LEVEL_W-1:0]   level,
	output logic                 clamped
);

	logic signed [CFG_W-1:0] log_scale_q, offset_db_q;

	l2_item_t l2_item;
	logic     en4, en5;

	logic                     valid_s4, clamped_s4;
	logic signed [PROD_W-1:0] prod_s4;

	logic                     valid_s5, clamped_s5;
	logic [LEVEL_W-1:0]       level_s5;

	logic [PROD_W-1:0]        rounded;
	logic signed [SHIFT_W-1:0] shifted;
	logic signed [SUM_W-1:0]  sum;
	logic [LEVEL_W-1:0]       sat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_scale_q <= LOG_SCALE_RST;
			offset_db_q <= OFFSET_DB_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOG_SCALE: log_scale_q <= cfg_wdata;
				REG_OFFSET_DB: offset_db_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	sldb_log2_unit u_log2 (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_bits (sample_bits),
		.l2_item     (l2_item),
		.l2_ready    (en4)
	);

	// Advance when empty or when the next stage moves
	assign en5 = !valid_s5 || out_ready;
	assign en4 = !valid_s4 || en5;

	// Stage 4: scale multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en4) begin
			valid_s4 <= l2_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			clamped_s4 <= l2_item.clamped;
			prod_s4    <= PROD_W'(l2_item.l2) * PROD_W'(log_scale_q);
		end
	end

	// Stage 5: round half up, drop fraction bits, add offset, saturate
	assign rounded = prod_s4 + ROUND_HALF;
	assign shifted = $signed(rounded[PROD_W-1:DROP_BITS]);
	assign sum     = SUM_W'(shifted) + SUM_W'(offset_db_q);

	always_comb begin
		if (sum[SUM_W-1:LEVEL_W-1] == '0 || sum[SUM_W-1:LEVEL_W-1] == '1) begin
			sat = sum[LEVEL_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(LEVEL_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(LEVEL_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			clamped_s5 <= clamped_s4;
			level_s5   <= sat;
		end
	end

	assign out_valid = valid_s5;
	assign level     = level_s5;
	assign clamped   = clamped_s5;

	`SLDB_ASSERT(a_ready_when_out_free, !valid_s5 |-> in_ready)
	`SLDB_ASSERT(a_s4_hold, (valid_s4 && !en5) |=> (valid_s4 && $stable(prod_s4)))
	`SLDB_ASSERT_RST(a_rst_out_empty, !arst_n |=> (!valid_s4 && !valid_s5))

endmodule
